### hw/rtl/tlik_pkg.sv
package tlik_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int FractionBitsDefault = 12;

  // Angle accumulator width (Q2.30 plus headroom)
  localparam int ZW = 34;
  // CORDIC datapath width: normalized magnitudes reach 2^41 and grow by ~1.65
  localparam int CW = 45;

  localparam logic signed [ZW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;

  typedef enum logic [1:0] {
    ACT_PLAIN    = 2'd0,
    ACT_FORWARD  = 2'd1,
    ACT_BACKWARD = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_LINK  = 2'd0,
    REG_BASE  = 2'd1,
    REG_ELBOW = 2'd2,
    REG_WRIST = 2'd3
  } reg_idx_t;

  // Arctangent of 2^-i in Q30
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        0: r = 34'sd843314857;
        1: r = 34'sd497837829;
        2: r = 34'sd263043837;
        3: r = 34'sd133525159;
        4: r = 34'sd67021687;
        5: r = 34'sd33543516;
        6: r = 34'sd16775851;
        7: r = 34'sd8388437;
        8: r = 34'sd4194283;
        9: r = 34'sd2097149;
        default: r = (i <= 30) ? (ZW'(1) <<< (30 - i)) : '0;
      endcase
      return r;
    end
  endfunction

endpackage

### hw/rtl/tlik_isqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage
module tlik_isqrt import tlik_pkg::*; #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [63:0]   in_n,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [31:0]   out_root,
  output logic [SW-1:0] out_side
);

  logic [32:0]   rem  [0:32];
  logic [31:0]   root [0:32];
  logic [63:0]   num  [0:32];
  logic [SW-1:0] side [0:32];
  logic          vld  [0:32];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign num[0]  = in_n;
  assign side[0] = in_side;
  assign vld[0]  = in_vld;

  for (genvar k = 0; k < 32; k++) begin : g_st
    logic [34:0] trial;
    logic [34:0] cand;
    logic        ok;
    assign cand  = {rem[k], num[k][63:62]};
    assign trial = {1'b0, root[k], 2'b01};
    assign ok    = cand >= trial;
    // Advance one bit of the root
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1]  <= ok ? 33'(cand - trial) : cand[32:0];
        root[k+1] <= {root[k][30:0], ok};
        num[k+1]  <= {num[k][61:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_vld  = vld[32];
  assign out_root = root[32];
  assign out_side = side[32];

endmodule

### hw/rtl/tlik_cordic.sv
// Pipelined CORDIC vectoring atan2, one rotation per stage
module tlik_cordic import tlik_pkg::*; #(
  parameter int STAGES = CordicStagesDefault,
  parameter int SW     = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [CW-1:0] in_x,
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic signed [ZW-1:0] out_z,
  output logic [SW-1:0]        out_side
);

  localparam int NW = $clog2(CW);

  // Stage 0: quadrant fold and zero detect (registered)
  logic                 f_vld, f_zero;
  logic signed [CW-1:0] f_x, f_y;
  logic signed [ZW-1:0] f_z;
  logic [SW-1:0]        f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= in_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f_side <= in_side;
      f_zero <= (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
        if (in_y >= 0) begin
          f_x <= in_y; f_y <= -in_x; f_z <= HalfPiQ30;
        end else begin
          f_x <= -in_y; f_y <= in_x; f_z <= -HalfPiQ30;
        end
      end else begin
        f_x <= in_x; f_y <= in_y; f_z <= '0;
      end
    end
  end

  // Stage 1: normalize so magnitude sits in [2^40, 2^41)
  logic [CW-1:0] mag;
  logic [NW-1:0] lz;
  always_comb begin
    logic [CW-1:0] ay;
    ay  = f_y[CW-1] ? CW'(-f_y) : CW'(f_y);
    mag = (CW'(f_x) > ay) ? CW'(f_x) : ay;
    lz  = '0;
    for (int b = 0; b <= 40; b++) begin
      if (mag[b]) lz = NW'(40 - b);
    end
  end

  logic                 n_vld, n_zero;
  logic signed [CW-1:0] n_x, n_y;
  logic signed [ZW-1:0] n_z;
  logic [SW-1:0]        n_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (adv) begin
      n_vld <= f_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      n_x    <= f_x <<< lz;
      n_y    <= f_y <<< lz;
      n_z    <= f_z;
      n_zero <= f_zero;
      n_side <= f_side;
    end
  end

  // Rotation stages
  logic signed [CW-1:0] xs [0:STAGES];
  logic signed [CW-1:0] ys [0:STAGES];
  logic signed [ZW-1:0] zs [0:STAGES];
  logic                 zr [0:STAGES];
  logic                 vs [0:STAGES];
  logic [SW-1:0]        ss [0:STAGES];

  assign xs[0] = n_x;
  assign ys[0] = n_y;
  assign zs[0] = n_z;
  assign zr[0] = n_zero;
  assign vs[0] = n_vld;
  assign ss[0] = n_side;

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam int SH = (i > CW - 1) ? CW - 1 : i;
    localparam logic signed [ZW-1:0] AT = atan_q30(i);
    logic signed [CW-1:0] dx, dy;
    assign dx = ys[i] >>> SH;
    assign dy = xs[i] >>> SH;
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (adv) begin
        vs[i+1] <= vs[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        zr[i+1] <= zr[i];
        ss[i+1] <= ss[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + dx; ys[i+1] <= ys[i] - dy; zs[i+1] <= zs[i] + AT;
        end else begin
          xs[i+1] <= xs[i] - dx; ys[i+1] <= ys[i] + dy; zs[i+1] <= zs[i] - AT;
        end
      end
    end
  end

  assign out_vld  = vs[STAGES];
  assign out_z    = zr[STAGES] ? '0 : zs[STAGES];
  assign out_side = ss[STAGES];

endmodule

### hw/rtl/two_link_planar_inverse_kinematics.sv
// Two-link planar inverse kinematics, equal link lengths.
// Input channel: in_valid/in_stall carry action, target_x, target_y; one beat
// is taken at every edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carry base_angle, elbow_angle,
// wrist_angle and unreachable; one result beat per input beat, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. Stages, in
// order: squares, 32-stage square root, two CORDIC prep stages, the CORDIC
// rotation stages, angle assembly.
// The whole pipeline advances together; in_stall is high whenever the final
// output register holds a beat that out_stall blocks, so a stall freezes
// every stage and nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values.
module two_link_planar_inverse_kinematics import tlik_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDefault,
  parameter int FRACTION_BITS = FractionBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] base_angle,
  output logic signed [15:0] elbow_angle,
  output logic signed [15:0] wrist_angle,
  output logic               unreachable,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef struct packed {
    logic [1:0]         act;
    logic signed [16:0] x;     // kept for phi
    logic signed [16:0] y;
    logic signed [33:0] r2m;   // r2 - d
    logic               zero;
    logic               far;
  } side_t;

  localparam int SW = $bits(side_t);

  logic [14:0]        link_length;
  logic signed [15:0] base_offset, elbow_offset, wrist_offset;
  logic               adv;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      link_length  <= 15'd1024;
      base_offset  <= '0;
      elbow_offset <= '0;
      wrist_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_LINK:  link_length  <= cfg_data[14:0];
        REG_BASE:  base_offset  <= cfg_data;
        REG_ELBOW: elbow_offset <= cfg_data;
        REG_WRIST: wrist_offset <= cfg_data;
        default:   link_length  <= link_length;
      endcase
    end
  end

  // Stage A: squares
  logic        a_vld;
  logic [1:0]  a_act;
  logic signed [15:0] a_x, a_y;
  logic [31:0] a_xx, a_yy, a_ll;
  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (adv) a_vld <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_act <= action;
      a_x   <= target_x;
      a_y   <= target_y;
      a_xx  <= 32'(32'(target_x) * 32'(target_x));
      a_yy  <= 32'(32'(target_y) * 32'(target_y));
      a_ll  <= 32'(link_length) * 32'(link_length);
    end
  end

  // Stage B: r2, d and range tests
  logic        b_vld, b_zero, b_far;
  logic [1:0]  b_act;
  logic signed [15:0] b_x, b_y;
  logic [32:0] b_r2;
  logic [33:0] b_d;
  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (adv) b_vld <= a_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_act  <= a_act;
      b_x    <= a_x;
      b_y    <= a_y;
      b_r2   <= 33'(a_xx) + 33'(a_yy);
      b_d    <= {1'b0, a_ll, 1'b0};
      b_zero <= (a_xx == '0) && (a_yy == '0);
      b_far  <= (35'(a_xx) + 35'(a_yy)) > {1'b0, a_ll, 2'b00};
    end
  end

  // Stage C: radicand r2*(4L^2 - r2)
  logic        c_vld;
  side_t       c_side;
  logic [63:0] c_rad;
  logic [34:0] fr;
  always_comb fr = {b_d, 1'b0} - 35'(b_r2);
  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (adv) c_vld <= b_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_side.act  <= b_act;
      c_side.x    <= 17'(b_x);
      c_side.y    <= 17'(b_y);
      c_side.r2m  <= 34'($signed({1'b0, b_r2}) - $signed(b_d));
      c_side.zero <= b_zero;
      c_side.far  <= b_far;
      c_rad <= (b_zero || b_far) ? '0 : 64'(b_r2) * 64'(fr[33:0]);
    end
  end

  logic        q_vld;
  logic [31:0] q_root;
  side_t       q_side;
  tlik_isqrt #(.SW(SW)) u_sqrt (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(c_vld), .in_n(c_rad), .in_side(c_side),
    .out_vld(q_vld), .out_root(q_root), .out_side(q_side)
  );

  // Both angles go through twin CORDIC pipes side by side
  logic               ka_vld, kp_vld;
  logic signed [ZW-1:0] ka_z, kp_z;
  side_t              ka_side, kp_side;

  tlik_cordic #(.STAGES(CORDIC_STAGES), .SW(SW)) u_alpha (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(q_vld),
    .in_y(CW'($signed({1'b0, q_root}))), .in_x(CW'(q_side.r2m)),
    .in_side(q_side),
    .out_vld(ka_vld), .out_z(ka_z), .out_side(ka_side)
  );

  tlik_cordic #(.STAGES(CORDIC_STAGES), .SW(SW)) u_phi (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(q_vld),
    .in_y(CW'(q_side.y)), .in_x(CW'(q_side.x)),
    .in_side(q_side),
    .out_vld(kp_vld), .out_z(kp_z), .out_side(kp_side)
  );

  // Stage E: joint angles in Q30
  localparam int SH = 30 - FRACTION_BITS;
  localparam int AW = ZW + 3;
  logic               e_vld, e_unr;
  logic [1:0]         e_act;
  logic signed [AW-1:0] e_b, e_e, e_w;
  logic signed [ZW-1:0] alpha;
  assign alpha = ka_side.zero ? PiQ30 : (ka_side.far ? '0 : ka_z);
  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else if (adv) e_vld <= ka_vld && kp_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      e_act <= kp_side.act;
      e_unr <= ka_side.zero || ka_side.far;
      e_b <= AW'(kp_z) + AW'(alpha >>> 1) + AW'(HalfPiQ30)
             + AW'(1 <<< (SH - 1));
      e_e <= AW'(PiQ30) - AW'(alpha) + AW'(1 <<< (SH - 1));
      e_w <= AW'(kp_z) + AW'(alpha >>> 1) - AW'(alpha) + AW'(PiQ30)
             + AW'(HalfPiQ30) + AW'(1 <<< (SH - 1));
    end
  end

  // Stage F: round, apply offsets
  localparam int RW = AW - SH + 2;
  logic               f_vld, f_unr;
  logic signed [RW-1:0] f_b, f_e, f_w;
  logic signed [RW-1:0] ob, oe, ow;
  always_comb begin
    ob = '0; oe = '0; ow = '0;
    case (action_t'(e_act))
      ACT_FORWARD: begin
        ob = RW'(base_offset); oe = RW'(elbow_offset); ow = RW'(wrist_offset);
      end
      ACT_BACKWARD: begin
        ob = -RW'(base_offset); oe = RW'(elbow_offset); ow = -RW'(wrist_offset);
      end
      default: begin
        ob = '0;
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (adv) f_vld <= e_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f_unr <= e_unr;
      f_b <= RW'(e_b >>> SH) + ob;
      f_e <= RW'(e_e >>> SH) + oe;
      f_w <= RW'(e_w >>> SH) + ow;
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [RW-1:0] v);
    begin
      if (v > RW'(32767)) return 16'sh7fff;
      else if (v < -RW'(32768)) return 16'sh8000;
      else return v[15:0];
    end
  endfunction

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= f_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      base_angle  <= sat16(f_b);
      elbow_angle <= sat16(f_e);
      wrist_angle <= sat16(f_w);
      unreachable <= f_unr;
    end
  end

endmodule

### hw/rtl/tlik_checker.sv
module tlik_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] elbow_angle,
  input logic               unreachable,
  input logic               cfg_ready
);

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(elbow_angle) && $stable(unreachable))
    else $error("stalled result changed");

  // Input is stalled only while a result is blocked
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Configuration never blocks
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

  // Reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind two_link_planar_inverse_kinematics tlik_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .elbow_angle(elbow_angle),
  .unreachable(unreachable), .cfg_ready(cfg_ready)
);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tlik_pkg::*;

  localparam logic [1:0] ActReserved = 2'd3;
  localparam int         DrainCycles = 70;
  localparam int         LongHold    = 300;
  localparam int         StallLimit  = 20000;

  typedef struct {
    logic signed [15:0] base;
    logic signed [15:0] elbow;
    logic signed [15:0] wrist;
    logic               flag;
  } pose_t;

  // Scoreboard: solves each accepted target and checks poses in order
  class pose_board;
    logic [14:0]        arm_len;
    logic signed [15:0] off_base, off_elbow, off_wrist;
    pose_t              pending_poses[$];
    int                 errors;
    int                 checked;
    int                 flagged;
    longint             atan_tab[10] = '{843314857, 497837829, 263043837, 133525159,
                                         67021687, 33543516, 16775851, 8388437,
                                         4194283, 2097149};

    function new();
      arm_len = 15'd1024; off_base = 0; off_elbow = 0; off_wrist = 0;
      errors = 0; checked = 0; flagged = 0;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Vectoring-mode CORDIC angle of (xv, yv), Q30
    function longint vector_angle(longint yv, longint xv);
      longint z = 0;
      longint t, mag, ay, dx, dy, step_ang;
      if (yv == 0 && xv == 0) return 0;
      if (xv < 0) begin
        t = xv;
        if (yv >= 0) begin
          xv = yv; yv = -t; z = longint'(HalfPiQ30);
        end else begin
          xv = -yv; yv = t; z = -longint'(HalfPiQ30);
        end
      end
      ay = (yv < 0) ? -yv : yv;
      mag = (xv > ay) ? xv : ay;
      while (mag < (64'sd1 <<< 40)) begin
        xv *= 2; yv *= 2; mag *= 2;
      end
      for (int i = 0; i < CordicStagesDefault; i++) begin
        step_ang = (i < 10) ? atan_tab[i] : (64'sd1 <<< (30 - i));
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv > 0) begin
          xv += dx; yv -= dy; z += step_ang;
        end else begin
          xv -= dx; yv += dy; z -= step_ang;
        end
      end
      return z;
    endfunction

    // Round Q30 to Q12, apply offset, saturate
    function logic signed [15:0] to_q12(longint q30, longint off, int sgn);
      longint v;
      v = (q30 + (64'sd1 <<< 17)) >>> 18;
      v += sgn * off;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void note_target(logic [1:0] act, logic signed [15:0] tx,
                              logic signed [15:0] ty);
      longint x = tx;
      longint y = ty;
      longint len = arm_len;
      longint r2, d, alpha, phi, th1, th2, th3;
      int     sb = 0, se = 0, sw = 0;
      pose_t  p;
      r2 = x * x + y * y;
      d = 2 * len * len;
      p.flag = 1'b1;
      if (r2 == 0) begin
        alpha = longint'(PiQ30);
      end else if (r2 > 2 * d) begin
        alpha = 0;
      end else begin
        p.flag = 1'b0;
        alpha = vector_angle(longint'(floor_sqrt(r2 * (2 * d - r2))), r2 - d);
      end
      phi = vector_angle(y, x);
      th2 = -alpha;
      th1 = phi + (alpha >>> 1);
      th3 = th1 + th2;
      case (act)
        ACT_FORWARD: begin sb = 1; se = 1; sw = 1; end
        ACT_BACKWARD: begin sb = -1; se = 1; sw = -1; end
        default: ;
      endcase
      p.base  = to_q12(th1 + longint'(HalfPiQ30), off_base, sb);
      p.elbow = to_q12(th2 + longint'(PiQ30), off_elbow, se);
      p.wrist = to_q12(th3 + longint'(PiQ30) + longint'(HalfPiQ30), off_wrist, sw);
      pending_poses.push_back(p);
    endfunction

    function void check_pose(pose_t got);
      pose_t e;
      if (pending_poses.size() == 0) begin
        $display("%0t: pose beat with nothing pending: %0d %0d %0d %0b", $time,
                 got.base, got.elbow, got.wrist, got.flag);
        errors++;
        return;
      end
      e = pending_poses.pop_front();
      checked++;
      if (got.flag) flagged++;
      if (got.base !== e.base) begin
        $display("%0t: base_angle expected %0d actual %0d", $time, e.base, got.base);
        errors++;
      end
      if (got.elbow !== e.elbow) begin
        $display("%0t: elbow_angle expected %0d actual %0d", $time, e.elbow, got.elbow);
        errors++;
      end
      if (got.wrist !== e.wrist) begin
        $display("%0t: wrist_angle expected %0d actual %0d", $time, e.wrist, got.wrist);
        errors++;
      end
      if (got.flag !== e.flag) begin
        $display("%0t: unreachable expected %0b actual %0b", $time, e.flag, got.flag);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         action = ACT_PLAIN;
  logic signed [15:0] target_x = 0;
  logic signed [15:0] target_y = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [15:0] base_angle, elbow_angle, wrist_angle;
  logic               unreachable;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_LINK;
  logic [15:0]        cfg_data = 0;

  pose_board board = new();
  bit        idle_on = 1;
  bit        long_req = 0;
  int        stall_left = 0;
  int        quiet_cycles = 0;
  int        sent = 0;

  two_link_planar_inverse_kinematics DUT (.*);

  always #1 clk = ~clk;

  // Receiver: random stall bursts plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (long_req) begin
      stall_left = LongHold;
      long_req = 0;
    end else if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 9);
    out_stall <= (stall_left > 0);
  end

  // Check every pose beat
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_pose('{base_angle, elbow_angle, wrist_angle, unreachable});
  end

  // Watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("two_link_planar_inverse_kinematics test failed");
      $finish;
    end
  end

  task automatic send_target(logic [1:0] act, logic signed [15:0] tx,
                             logic signed [15:0] ty);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    target_x <= tx;
    target_y <= ty;
    do @(posedge clk); while (in_stall);
    board.note_target(act, tx, ty);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_poses.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Load all four registers back to back; only call while drained
  task automatic configure(logic [15:0] len_word, logic signed [15:0] b,
                           logic signed [15:0] e, logic signed [15:0] w);
    logic [15:0] vals[4];
    vals = '{len_word, b, e, w};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 0;
    board.arm_len = len_word[14:0];
    board.off_base = b;
    board.off_elbow = e;
    board.off_wrist = w;
  endtask

  function automatic logic signed [15:0] rand_coord(int reach);
    int v;
    v = $urandom_range(0, 2 * reach) - reach;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Random targets: mostly within reach of the arm, some anywhere
  task automatic random_targets(int n);
    int reach;
    logic [1:0] act;
    reach = 2 * int'(board.arm_len) + 2;
    if (reach > 32768) reach = 32768;
    for (int i = 0; i < n; i++) begin
      act = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1: send_target(act, 16'($urandom), 16'($urandom));
        2: send_target(act, rand_coord(reach), 0);
        3: send_target(act, 0, rand_coord(reach));
        default: send_target(act, rand_coord(reach * 3 / 4), rand_coord(reach * 3 / 4));
      endcase
    end
  endtask

  initial begin
    logic signed [15:0] pts[20][2];
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed: origin, full reach, just past reach, axes, corners
    pts = '{'{0, 0}, '{2048, 0}, '{2049, 0}, '{0, 2048}, '{-2048, 0}, '{0, -2048},
            '{-32768, -32768}, '{32767, 32767}, '{-32768, 32767}, '{32767, -32768},
            '{1024, 1024}, '{-1, 0}, '{1, 1}, '{0, -1}, '{-1448, -1448},
            '{-2047, 1}, '{1, -2047}, '{700, -300}, '{-5, 2040}, '{16, -16}};
    for (int i = 0; i < 20; i++) send_target(i[1:0], pts[i][0], pts[i][1]);
    drain();

    configure(16'd1, 16'sh7FFF, -16'sd32768, 16'sh7FFF);
    send_target(ACT_FORWARD, 2, 0);
    send_target(ACT_BACKWARD, 1, 1);
    send_target(ActReserved, 3, 0);
    random_targets(150);
    drain();

    // Long receiver hold-off while targets keep coming
    configure(16'h7FFF, -16'sd32768, 16'sh7FFF, -16'sd32768);
    long_req = 1;
    random_targets(200);
    drain();

    configure(16'd0, 16'sd1234, -16'sd77, 16'sd4000);
    send_target(ACT_PLAIN, 0, 0);
    random_targets(100);
    drain();

    // Sender pauses mid-phase until all poses are back
    configure(16'd1024, -16'sd6434, 16'sd3217, 16'sd12867);
    random_targets(150);
    drain();
    random_targets(150);
    drain();

    for (int p = 0; p < 3; p++) begin
      configure(16'h8000 | 16'($urandom_range(1, 32767)), 16'($urandom),
                16'($urandom), 16'($urandom));
      random_targets(200);
      drain();
    end

    configure(16'd4096 + 16'($urandom_range(0, 4096)), 16'($urandom),
              16'($urandom), 16'($urandom));
    idle_on = 0;
    random_targets(180);
    drain();

    $display("Sent %0d targets over 9 register settings; %0d poses checked, %0d unreachable.",
             sent, board.checked, board.flagged);
    if (board.errors == 0 && board.pending_poses.size() == 0) begin
      $display("two_link_planar_inverse_kinematics test passed");
    end else begin
      $display("two_link_planar_inverse_kinematics test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tlik_pkg.sv
hw/rtl/tlik_isqrt.sv
hw/rtl/tlik_cordic.sv
hw/rtl/two_link_planar_inverse_kinematics.sv
hw/rtl/tlik_checker.sv
tb/sv/tb_top.sv
